>>> rtl/udpcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpcs_pkg
// Shared types, constants and the ones'-complement adder for the UDP
// checksum core.
// ----------------------------------------------------------------------------
package udpcs_pkg;

  // protocol word of the pseudo-header (UDP)
  localparam logic [15:0] UDP_PROTOCOL_WORD = 16'h0011;
  // mask applied to a word holding a single valid byte
  localparam logic [15:0] ODD_BYTE_MASK = 16'hff00;
  localparam logic [15:0] WORD_ONES = 16'hffff;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_ADDRESS      = 2'd0;
  localparam logic [1:0] REG_DESTINATION_ADDRESS = 2'd1;
  localparam logic [1:0] REG_CHECKSUM_MODE       = 2'd2;

  localparam int CFG_DATA_WIDTH = 32;

  // checksum modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_NONE   = 2'd1,
    MODE_BAD    = 2'd2,
    MODE_HW     = 2'd3
  } checksum_mode_t;

  // input transfer payload
  typedef struct packed {
    logic [15:0] data_word;
    logic [1:0]  valid_bytes;
    logic        last_word;
  } udpcs_in_t;

  // result transfer payload
  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] datagram_length;
    logic        length_overflow;
  } udpcs_out_t;

  // finished datagram totals handed from accumulator to finisher
  typedef struct packed {
    logic [15:0] data_sum;
    logic [15:0] byte_count;
    logic        overflow;
  } udpcs_fin_t;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

>>> rtl/udpcs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpcs_cfg
// Configuration registers and the registered address part of the
// pseudo-header sum.
// ----------------------------------------------------------------------------
module udpcs_cfg import udpcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  output logic [15:0]               addr_sum,
  output checksum_mode_t            mode
);

  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] addr_sum_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_address      <= '0;
      destination_address <= '0;
      mode                <= MODE_NORMAL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SOURCE_ADDRESS:      source_address      <= cfg_wdata[31:0];
        REG_DESTINATION_ADDRESS: destination_address <= cfg_wdata[31:0];
        REG_CHECKSUM_MODE:       mode                <= checksum_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // addresses and protocol word folded together
  always_comb begin
    addr_sum_next = oc_add(source_address[31:16], source_address[15:0]);
    addr_sum_next = oc_add(addr_sum_next, destination_address[31:16]);
    addr_sum_next = oc_add(addr_sum_next, destination_address[15:0]);
    addr_sum_next = oc_add(addr_sum_next, UDP_PROTOCOL_WORD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_sum <= UDP_PROTOCOL_WORD;
    end else begin
      addr_sum <= addr_sum_next;
    end
  end

endmodule

>>> rtl/udpcs_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpcs_accum
// Running ones'-complement sum and byte count over the word stream; hands
// the totals of each finished datagram to a holding register.
// ----------------------------------------------------------------------------
module udpcs_accum import udpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  udpcs_in_t  in_item,
  input  logic       fin_take,
  output logic       fin_valid,
  output udpcs_fin_t fin
);

  logic [15:0] running_sum;
  logic [15:0] byte_count;
  logic        count_overflowed;

  logic [15:0] word;
  logic [1:0]  nbytes;
  logic [16:0] count_wide;
  logic [15:0] running_sum_next;
  logic [15:0] byte_count_next;
  logic        count_overflowed_next;

  // add the incoming word to the totals
  always_comb begin
    nbytes = (in_item.valid_bytes == 2'd3) ? 2'd2 : in_item.valid_bytes;
    word   = (nbytes == 2'd1) ? (in_item.data_word & ODD_BYTE_MASK) : in_item.data_word;
    count_wide            = {1'b0, byte_count} + {15'b0, nbytes};
    running_sum_next      = running_sum;
    byte_count_next       = byte_count;
    count_overflowed_next = count_overflowed;
    if (nbytes != 2'd0) begin
      running_sum_next      = oc_add(running_sum, word);
      byte_count_next       = count_wide[15:0];
      count_overflowed_next = count_overflowed | count_wide[16];
    end
  end

  // accumulators, cleared after each datagram
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= '0;
      byte_count       <= '0;
      count_overflowed <= 1'b0;
    end else if (in_take) begin
      if (in_item.last_word) begin
        running_sum      <= '0;
        byte_count       <= '0;
        count_overflowed <= 1'b0;
      end else begin
        running_sum      <= running_sum_next;
        byte_count       <= byte_count_next;
        count_overflowed <= count_overflowed_next;
      end
    end
  end

  // holding register for finished totals
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_take && in_item.last_word) begin
      fin_valid <= 1'b1;
    end else if (fin_take) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_item.last_word) begin
      fin.data_sum   <= running_sum_next;
      fin.byte_count <= byte_count_next;
      fin.overflow   <= count_overflowed_next;
    end
  end

endmodule

>>> rtl/udpcs_final.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpcs_final
// Adds the pseudo-header to the finished totals, applies the checksum mode
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module udpcs_final import udpcs_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           fin_valid,
  input  udpcs_fin_t     fin,
  input  logic [15:0]    addr_sum,
  input  checksum_mode_t mode,
  output logic           fin_take,
  output logic           out_valid,
  input  logic           out_stall,
  output udpcs_out_t     out_data
);

  logic        out_free;
  logic [15:0] pseudo;
  logic [15:0] total;
  logic [15:0] inv_total;
  logic [15:0] bumped;
  logic [15:0] result;

  assign out_free = !out_valid || !out_stall;
  assign fin_take = fin_valid && out_free;

  // pseudo-header, total and mode selection
  always_comb begin
    pseudo    = oc_add(addr_sum, fin.byte_count);
    total     = oc_add(pseudo, fin.data_sum);
    inv_total = ~total;
    bumped    = inv_total + 16'd1;
    unique case (mode)
      MODE_NORMAL: result = (inv_total == 16'd0) ? WORD_ONES : inv_total;
      MODE_NONE:   result = 16'd0;
      MODE_BAD:    result = (bumped == 16'd0) ? 16'd1 : bumped;
      MODE_HW:     result = pseudo;
      default:     result = 16'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_data.checksum        <= result;
      out_data.datagram_length <= fin.byte_count;
      out_data.length_overflow <= fin.overflow;
    end
  end

endmodule

>>> rtl/udp_checksum_with_pseudo_header_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_checksum_with_pseudo_header_core
// UDP over IPv4 checksum generator with pseudo-header insertion.
// ----------------------------------------------------------------------------
// The core takes one 16-bit datagram word per clock while in_stall is low,
// first byte in the high bits, with the checksum field of the stream zero.
// Every word is folded into a ones'-complement running sum and byte count
// the cycle it is transferred. After the last word, the result (checksum by
// mode, counted length and length-wrap flag) goes through a holding register
// and then the pseudo-header add into the output register. Datagrams may
// follow each other back to back; input stall only rises when both the
// holding and output registers are full and the output is stalled.
// Addresses and mode are sampled as the totals leave the holding register;
// the folded address sum is registered from the written address registers.
// ----------------------------------------------------------------------------
module udp_checksum_with_pseudo_header_core import udpcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  udpcs_in_t                 in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output udpcs_out_t                out_data
);

  logic           in_take;
  logic           fin_valid;
  logic           fin_take;
  udpcs_fin_t     fin;
  logic [15:0]    addr_sum;
  checksum_mode_t mode;

  // stall only when the holding register cannot drain
  assign in_stall = fin_valid && !fin_take;
  assign in_take  = in_valid && !in_stall;

  udpcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .addr_sum  (addr_sum),
    .mode      (mode)
  );

  udpcs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_item   (in_data),
    .fin_take  (fin_take),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  udpcs_final u_final (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .addr_sum  (addr_sum),
    .mode      (mode),
    .fin_take  (fin_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
